/* src/tfks_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfks_pkg
// Shared types, constants and GF/q-permutation helpers for the key schedule.
// ----------------------------------------------------------------------------
package tfks_pkg;

  localparam int unsigned RoundKeyWords = 40;
  localparam int unsigned SboxWords     = 4;
  localparam logic [8:0]  GfMdsPoly     = 9'h169;
  localparam logic [8:0]  GfRsPoly      = 9'h14d;
  localparam logic [31:0] ByteSpread    = 32'h0101_0101;

  typedef logic [3:0] nib_t;
  typedef nib_t nib_tab_t [16];

  localparam nib_tab_t NibRot = '{4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3, 4'd11,
                                  4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7, 4'd15};
  localparam nib_tab_t NibAsh = '{4'd0, 4'd9, 4'd2, 4'd11, 4'd4, 4'd13, 4'd6, 4'd15,
                                  4'd8, 4'd1, 4'd10, 4'd3, 4'd12, 4'd5, 4'd14, 4'd7};
  localparam nib_tab_t PermA0 = '{8, 1, 7, 13, 6, 15, 3, 2, 0, 11, 5, 9, 14, 12, 10, 4};
  localparam nib_tab_t PermA1 = '{2, 8, 11, 13, 15, 7, 6, 14, 3, 1, 9, 4, 0, 10, 12, 5};
  localparam nib_tab_t PermB0 = '{14, 12, 11, 8, 1, 2, 3, 5, 15, 4, 10, 6, 7, 0, 9, 13};
  localparam nib_tab_t PermB1 = '{1, 14, 2, 11, 4, 12, 3, 7, 6, 13, 10, 5, 15, 9, 0, 8};
  localparam nib_tab_t PermC0 = '{11, 10, 5, 14, 6, 13, 9, 0, 12, 8, 15, 3, 2, 4, 7, 1};
  localparam nib_tab_t PermC1 = '{4, 12, 7, 5, 1, 6, 9, 10, 0, 14, 13, 8, 2, 11, 3, 15};
  localparam nib_tab_t PermD0 = '{13, 7, 15, 4, 1, 2, 6, 14, 9, 11, 3, 0, 8, 5, 12, 10};
  localparam nib_tab_t PermD1 = '{11, 9, 5, 1, 12, 3, 13, 14, 6, 4, 7, 15, 2, 0, 8, 10};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RS,
    ST_HASH,
    ST_EMIT_RK,
    ST_EMIT_SB
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       store_word;
    logic       rs_start;
    logic       rs_step;
    logic       h_start;
    logic       h_step;
    logic [4:0] pair_idx;   // i/2 of round key pair
    logic       out_load_rk;
    logic       out_load_sb;
    logic [5:0] out_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rs_done;
    logic h_done;
  } dp_sts_t;

  function automatic logic [7:0] qperm(input logic sel, input logic [7:0] x);
    nib_t a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
    a0 = x[7:4];
    b0 = x[3:0];
    a1 = a0 ^ b0;
    b1 = NibRot[b0] ^ NibAsh[a0];
    a2 = sel ? PermA1[a1] : PermA0[a1];
    b2 = sel ? PermB1[b1] : PermB0[b1];
    a3 = a2 ^ b2;
    b3 = NibRot[b2] ^ NibAsh[a2];
    a4 = sel ? PermC1[a3] : PermC0[a3];
    b4 = sel ? PermD1[b3] : PermD0[b3];
    return {b4, a4};
  endfunction

  function automatic logic [7:0] mul_5b(input logic [7:0] x);
    logic [7:0] lo;
    unique case (x[1:0])
      2'd0: lo = 8'h00;
      2'd1: lo = {1'b0, GfMdsPoly[8:2]};
      2'd2: lo = GfMdsPoly[8:1];
      default: lo = GfMdsPoly[8:1] ^ {1'b0, GfMdsPoly[8:2]};
    endcase
    return x ^ (x >> 2) ^ lo;
  endfunction

  function automatic logic [7:0] mul_ef(input logic [7:0] x);
    logic [7:0] lo;
    unique case (x[1:0])
      2'd0: lo = 8'h00;
      2'd1: lo = GfMdsPoly[8:1] ^ {1'b0, GfMdsPoly[8:2]};
      2'd2: lo = GfMdsPoly[8:1];
      default: lo = {1'b0, GfMdsPoly[8:2]};
    endcase
    return x ^ (x >> 1) ^ (x >> 2) ^ lo;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage
`default_nettype wire

/* src/tfks_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfks_if
// Valid/ready channel interfaces for key words, subkeys and configuration.
// ----------------------------------------------------------------------------
interface tfks_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  modport source (output valid, output key_word, input ready);
  modport sink   (input valid, input key_word, output ready);
endinterface

interface tfks_subkey_if;
  logic        valid;
  logic        ready;
  logic [31:0] subkey_word;
  logic [5:0]  subkey_index;
  logic        last_word;
  modport source (output valid, output subkey_word, output subkey_index,
                  output last_word, input ready);
  modport sink   (input valid, input subkey_word, input subkey_index,
                  input last_word, output ready);
endinterface

interface tfks_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_halves;
  modport source (output valid, output key_halves, input ready);
  modport sink   (input valid, input key_halves, output ready);
endinterface
`default_nettype wire

/* src/tfks_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfks_datapath
// Key store, bytewise RS remainder unit, stage-serial h unit, output register.
// ----------------------------------------------------------------------------
module tfks_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        halves_i,
  input  wire logic [2:0]        wr_idx_i,
  input  wire logic [31:0]       key_word_i,
  input  wire tfks_pkg::dp_cmd_t cmd_i,
  output      tfks_pkg::dp_sts_t sts_o,
  output      logic [31:0]       out_word_o
);
  import tfks_pkg::*;

  logic [31:0] key_q [8];
  logic [31:0] sbox_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_word) key_q[wr_idx_i] <= key_word_i;
  end

  // RS remainder: one key pair per pass, one byte per cycle
  logic [1:0]  rs_pair_q, rs_pair_d;
  logic [2:0]  rs_cnt_q, rs_cnt_d;
  logic [31:0] rs_lo_q, rs_hi_q, rs_lo_d, rs_hi_d;
  logic        rs_done;
  logic [7:0]  rs_t;
  logic [8:0]  rs_u, rs_u2;
  logic [31:0] rs_hi_sh;
  logic [1:0]  rs_slot;
  logic [2:0]  rs_pair_base;
  logic [31:0] rs_hi_d_final;

  always_comb begin
    rs_pair_base = {rs_pair_q, 1'b0};
    rs_t     = rs_hi_q[31:24];
    rs_hi_sh = {rs_hi_q[23:0], rs_lo_q[31:24]};
    rs_u     = {rs_t, 1'b0};
    if (rs_t[7]) rs_u = rs_u ^ GfRsPoly;
    rs_hi_sh = rs_hi_sh ^ {24'h0, rs_t} ^ {8'h0, rs_u[7:0], 16'h0};
    rs_u2    = rs_u ^ {1'b0, rs_t >> 1};
    if (rs_t[0]) rs_u2 = rs_u2 ^ {1'b0, GfRsPoly[8:1]};
    rs_hi_d  = rs_hi_sh ^ {rs_u2[7:0], 24'h0} ^ {16'h0, rs_u2[7:0], 8'h0};
    rs_lo_d  = {rs_lo_q[23:0], 8'h0};
    rs_cnt_d = rs_cnt_q + 3'd1;
    rs_pair_d = rs_pair_q;
    rs_slot  = 2'(halves_i - 3'd1 - {1'b0, rs_pair_q});
    rs_done  = 1'b0;
    if (cmd_i.rs_start) begin
      rs_pair_d = '0;
      rs_cnt_d  = '0;
      rs_lo_d   = key_q[0];
      rs_hi_d   = key_q[1];
    end else if (cmd_i.rs_step && rs_cnt_q == 3'd7) begin
      rs_pair_d = rs_pair_q + 2'd1;
      rs_done   = ({1'b0, rs_pair_q} == halves_i - 3'd1);
      rs_lo_d   = key_q[3'(rs_pair_base + 3'd2)];
      rs_hi_d   = key_q[3'(rs_pair_base + 3'd3)];
    end
  end

  always_comb begin
    // value after the eighth byte step (before reload of next pair)
    rs_hi_d_final = rs_hi_sh ^ {rs_u2[7:0], 24'h0} ^ {16'h0, rs_u2[7:0], 8'h0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_pair_q <= '0;
      rs_cnt_q  <= '0;
      for (int i = 0; i < 4; i++) sbox_q[i] <= '0;
    end else begin
      if (cmd_i.rs_start || cmd_i.rs_step) begin
        rs_pair_q <= rs_pair_d;
        rs_cnt_q  <= rs_cnt_d;
      end
      if (cmd_i.rs_step && rs_cnt_q == 3'd7) sbox_q[rs_slot] <= rs_hi_d_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rs_start || cmd_i.rs_step) begin
      rs_lo_q <= rs_lo_d;
      rs_hi_q <= rs_hi_d;
    end
  end

  // h unit: one q layer per cycle, even and odd words in parallel.
  // Step 0..3 are the key layers l[3],l[2],l[1],l[0]; step 4 is MDS and PHT.
  logic [2:0]  h_step_q;
  logic [31:0] ha_q, hb_q;
  logic [31:0] ha_d, hb_d;
  logic [31:0] ka, kb;
  logic [3:0]  qsel;
  logic        h_done;
  logic [31:0] mds_a, mds_b, pht_a, pht_b, res1_q;
  logic [2:0]  h_first;

  function automatic logic [31:0] qlayer(input logic [31:0] x, input logic [3:0] s,
                                         input logic [31:0] k);
    return {qperm(s[3], x[31:24]), qperm(s[2], x[23:16]),
            qperm(s[1], x[15:8]), qperm(s[0], x[7:0])} ^ k;
  endfunction

  function automatic logic [31:0] mds(input logic [31:0] x);
    logic [7:0] f0, f1, f2, f3;
    f0 = qperm(1'b1, x[7:0]);
    f1 = qperm(1'b0, x[15:8]);
    f2 = qperm(1'b1, x[23:16]);
    f3 = qperm(1'b0, x[31:24]);
    return {mul_ef(f0), mul_ef(f0), mul_5b(f0), f0}
         ^ {f1, mul_5b(f1), mul_ef(f1), mul_ef(f1)}
         ^ {mul_ef(f2), f2, mul_ef(f2), mul_5b(f2)}
         ^ {mul_5b(f3), mul_ef(f3), f3, mul_5b(f3)};
  endfunction

  always_comb begin
    h_first = (halves_i == 3'd4) ? 3'd0 : (halves_i == 3'd3) ? 3'd1 : 3'd2;
    unique case (h_step_q[1:0])
      2'd0: begin qsel = 4'b1001; ka = key_q[6]; kb = key_q[7]; end
      2'd1: begin qsel = 4'b0011; ka = key_q[4]; kb = key_q[5]; end
      2'd2: begin qsel = 4'b1010; ka = key_q[2]; kb = key_q[3]; end
      default: begin qsel = 4'b1100; ka = key_q[0]; kb = key_q[1]; end
    endcase
  end

  // layer 3 applies outer q of pair (q0,q0,q1,q1) on top of inner-layer result
  function automatic logic [31:0] step_fn(input logic [2:0] st, input logic [31:0] x,
                                          input logic [3:0] s, input logic [31:0] k);
    logic [31:0] y;
    y = x;
    if (st == 3'd3)
      y = {qperm(1'b1, x[31:24]), qperm(1'b1, x[23:16]),
           qperm(1'b0, x[15:8]), qperm(1'b0, x[7:0])} ^ k;
    else
      y = qlayer(x, s, k);
    return y;
  endfunction

  always_comb begin
    logic [31:0] a0;
    a0 = ByteSpread * {26'h0, cmd_i.pair_idx, 1'b0};
    ha_d = ha_q;
    hb_d = hb_q;
    if (cmd_i.h_start) begin
      ha_d = a0;
      hb_d = a0 + ByteSpread;
    end else if (cmd_i.h_step && h_step_q != 3'd4) begin
      // step 2 is inner q of the l[1] layer: x -> q(x)^l1, step 3 -> q(y)^l0
      ha_d = step_fn(h_step_q, ha_q, qsel, ka);
      hb_d = step_fn(h_step_q, hb_q, qsel, kb);
    end
  end

  always_comb begin
    mds_a = mds(ha_q);
    mds_b = rotl(mds(hb_q), 8);
    pht_a = mds_a + mds_b;
    pht_b = rotl(mds_a + {mds_b[30:0], 1'b0}, 9);
    h_done = cmd_i.h_step && h_step_q == 3'd4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_step_q <= '0;
    end else if (cmd_i.h_start) begin
      h_step_q <= h_first;
    end else if (cmd_i.h_step && h_step_q != 3'd4) begin
      h_step_q <= h_step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    ha_q <= ha_d;
    hb_q <= hb_d;
    if (h_done) begin
      res1_q <= pht_b;
    end
  end

  // output word register; the even word loads straight from the h unit on done
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_rk) out_word_o <= cmd_i.out_idx[0] ? res1_q : pht_a;
    else if (cmd_i.out_load_sb) out_word_o <= sbox_q[cmd_i.out_idx[1:0]];
  end

  assign sts_o.rs_done = rs_done;
  assign sts_o.h_done  = h_done;

endmodule
`default_nettype wire

/* src/tfks_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfks_ctrl
// Sequencer: word collection, RS passes, 20 h passes and result handshake.
// ----------------------------------------------------------------------------
module tfks_ctrl #(
  parameter int unsigned ROUND_KEY_WORDS = tfks_pkg::RoundKeyWords
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        halves_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic [2:0]        wr_idx_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [5:0]        out_idx_o,
  output      logic              out_last_o,
  output      tfks_pkg::dp_cmd_t cmd_o,
  input  wire tfks_pkg::dp_sts_t sts_i
);
  import tfks_pkg::*;

  localparam logic [5:0]  LastIdx = 6'(ROUND_KEY_WORDS + SboxWords - 1);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [4:0] pair_q, pair_d;
  logic [5:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic       h_go_q, h_go_d;
  logic       accept, take, last_in;

  assign accept  = in_valid_i && in_ready_o;
  assign take    = ov_q && out_ready_i;
  assign last_in = accept && (cnt_q == {halves_i, 1'b0} - 4'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:    if (last_in) state_d = ST_RS;
      ST_RS:      if (sts_i.rs_done) state_d = ST_HASH;
      ST_HASH:    if (sts_i.h_done) state_d = ST_EMIT_RK;
      ST_EMIT_RK: begin
        if (take && idx_q[0]) begin
          state_d = (idx_q == 6'(ROUND_KEY_WORDS - 1)) ? ST_EMIT_SB : ST_HASH;
        end
      end
      ST_EMIT_SB: if (take && idx_q == LastIdx) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    pair_d = pair_q;
    idx_d = idx_q;
    ov_d = ov_q;
    h_go_d = 1'b0;
    cmd_o = '0;
    cmd_o.pair_idx = pair_q;
    cmd_o.out_idx  = idx_q;
    in_ready_o = (state_q == ST_LOAD);
    cmd_o.store_word = accept;
    if (accept) cnt_d = last_in ? 4'd0 : cnt_q + 4'd1;
    if (cfg_we_i) cnt_d = '0;
    cmd_o.rs_start = last_in;
    cmd_o.rs_step  = (state_q == ST_RS);
    if (state_q == ST_RS && sts_i.rs_done) begin
      pair_d = '0;
      idx_d  = '0;
      h_go_d = 1'b1;
    end
    cmd_o.h_start = h_go_q;
    cmd_o.h_step  = (state_q == ST_HASH) && !h_go_q;
    if (take) begin
      ov_d  = 1'b0;
      idx_d = idx_q + 6'd1;
    end
    unique case (state_q)
      ST_HASH: begin
        if (sts_i.h_done) begin
          ov_d = 1'b1;
          cmd_o.out_load_rk = 1'b1;
        end
      end
      ST_EMIT_RK: begin
        if (take && !idx_q[0]) begin
          ov_d = 1'b1;
          cmd_o.out_load_rk = 1'b1;
          cmd_o.out_idx = idx_q + 6'd1;
        end else if (take && idx_q == 6'(ROUND_KEY_WORDS - 1)) begin
          ov_d = 1'b1;
          cmd_o.out_load_sb = 1'b1;
          cmd_o.out_idx = '0;
        end else if (take) begin
          pair_d = pair_q + 5'd1;
          h_go_d = 1'b1;
        end
      end
      ST_EMIT_SB: begin
        if (take && idx_q != LastIdx) begin
          ov_d = 1'b1;
          cmd_o.out_load_sb = 1'b1;
          cmd_o.out_idx = 6'(idx_q + 6'd1 - 6'(ROUND_KEY_WORDS));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      pair_q  <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      h_go_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pair_q  <= pair_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
      h_go_q  <= h_go_d;
    end
  end

  assign wr_idx_o    = cnt_q[2:0];
  assign out_valid_o = ov_q;
  assign out_idx_o   = idx_q;
  assign out_last_o  = (idx_q == LastIdx);

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !in_ready_o) else $error("input ready while result pending");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(idx_q)) else $error("result dropped");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> idx_q <= LastIdx) else $error("index out of range");
`endif

endmodule
`default_nettype wire

/* src/twofish_key_schedule_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twofish_key_schedule_core
// Twofish key expansion: collects 4/6/8 key words, emits 40 subkeys + 4 S-keys.
// ----------------------------------------------------------------------------
// Sequence: after the last key word, the RS remainder is computed for each key
// pair, then each subkey pair passes through the shared h unit (one q layer per
// cycle) and its two words are emitted in turn, even word first.
// Throughput: one key word per cycle while loading; one result at a time.
// Reset: async active low; key_halves = 4, S-box key words zero, count zero.
module twofish_key_schedule_core #(
  parameter int unsigned ROUND_KEY_WORDS = tfks_pkg::RoundKeyWords
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tfks_cfg_if.sink   cfg,
  tfks_key_if.sink   key_in,
  tfks_subkey_if.source subkey_out
);
  import tfks_pkg::*;

  logic [2:0] halves_q, halves_eff;
  logic       cfg_we;
  logic [2:0] wr_idx;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [31:0] out_word;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) halves_q <= 3'd4;
    else if (cfg_we) halves_q <= cfg.key_halves;
  end

  assign halves_eff = (halves_q < 3'd2) ? 3'd2 : (halves_q > 3'd4) ? 3'd4 : halves_q;

  tfks_ctrl #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_ctrl (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_we),
    .halves_i   (halves_eff),
    .in_valid_i (key_in.valid),
    .in_ready_o (key_in.ready),
    .wr_idx_o   (wr_idx),
    .out_valid_o(subkey_out.valid),
    .out_ready_i(subkey_out.ready),
    .out_idx_o  (subkey_out.subkey_index),
    .out_last_o (subkey_out.last_word),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tfks_datapath u_dp (
    .clk_i, .rst_ni,
    .halves_i  (halves_eff),
    .wr_idx_i  (wr_idx),
    .key_word_i(key_in.key_word),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_word_o(out_word)
  );

  assign subkey_out.subkey_word = out_word;

endmodule
`default_nettype wire
